// File: rtl/table_linear_interpolator_unit_assert.svh
// assertion macros shared by the interpolator modules
`ifndef TABLE_LINEAR_INTERPOLATOR_UNIT_ASSERT_SVH
`define TABLE_LINEAR_INTERPOLATOR_UNIT_ASSERT_SVH

// property that must hold whenever the block is out of reset
`define TLI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the following clock edge
`define TLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// widths, status codes and shared types of the table interpolator
// ----------------------------------------------------------------------------
package tli_pkg;

    localparam int MaxRows   = 64;
    localparam int RowBits   = $clog2(MaxRows);
    localparam int CountBits = 7;
    localparam int DataBits  = 32;
    localparam int NumProp   = 7;
    localparam int FracBits  = 17;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_ABOVE = 2'd1;
    localparam logic [1:0] STATUS_BELOW = 2'd2;
    localparam logic [1:0] STATUS_EMPTY = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic signed [DataBits-1:0] word_t;
    typedef word_t [NumProp-1:0] prop_vec_t;

    // handshake between sequencer and serial arithmetic unit
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } unit_ctl_t;

endpackage

// File: rtl/tli_divider.sv
// ----------------------------------------------------------------------------
// tli_divider
// bit-serial restoring divider, frac = (num << 16) / den, one quotient bit a cycle
// ----------------------------------------------------------------------------
module tli_divider
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [32:0]                  num,
    input  logic [32:0]                  den,
    output logic                         busy,
    output logic                         done,
    output logic [tli_pkg::FracBits-1:0] quot
);
    import tli_pkg::*;

    localparam int Steps = 49;

    logic [33:0] rem_reg, rem_next;
    logic [48:0] dvd_reg, dvd_next;
    logic [32:0] den_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] shifted;
    logic [34:0] diff;

    always_comb
    begin
        shifted   = {rem_reg[32:0], dvd_reg[48]};
        diff      = {1'b0, shifted} - {2'b0, den_reg};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            rem_next  = '0;
            dvd_next  = {num[32:0], 16'd0};
            cnt_next  = 6'(Steps);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[34])
                rem_next = diff[33:0];
            else
                rem_next = shifted;
            dvd_next = {dvd_reg[47:0], !diff[34]};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        if (start && !busy_reg)
            den_reg <= den;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = dvd_reg[FracBits-1:0];

    `include "table_linear_interpolator_unit_assert.svh"
    `TLI_ASSERT(div_cnt_idle, busy_reg || (cnt_reg == 6'd0), "divider count left over")
    `TLI_ASSERT_NEXT(div_done_end, busy_reg && (cnt_reg == 6'd1), done_reg && !busy_reg, "divider end missed")
    `TLI_ASSERT(div_done_excl, !(done_reg && busy_reg), "divider done while busy")

endmodule

// File: rtl/tli_serial_mac.sv
// ----------------------------------------------------------------------------
// tli_serial_mac
// shift-add multiplier, v_lo + (frac * d) >>> 16, one frac bit a cycle
// ----------------------------------------------------------------------------
module tli_serial_mac
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tli_pkg::FracBits-1:0] frac,
    input  tli_pkg::word_t               v_lo,
    input  tli_pkg::word_t               v_hi,
    output logic                         busy,
    output logic                         done,
    output tli_pkg::word_t               result
);
    import tli_pkg::*;

    // accumulator holds (frac[k-1:0]*d) >> k after k steps, low bits into lsb_reg
    logic signed [33:0] acc_reg, acc_next;
    logic [15:0]        lsb_reg;
    logic signed [32:0] d_reg;
    logic [FracBits-1:0] m_reg;
    word_t              lo_reg;
    logic [4:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic signed [34:0] sum;

    always_comb
    begin
        sum       = 35'(acc_reg) + (m_reg[0] ? 35'(d_reg) : 35'sd0);
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            acc_next  = '0;
            cnt_next  = 5'(FracBits);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = sum[34:1];
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start && !busy_reg)
        begin
            d_reg  <= 33'(v_hi) - 33'(v_lo);
            m_reg  <= frac;
            lo_reg <= v_lo;
        end
        else if (busy_reg)
        begin
            m_reg   <= m_reg >> 1;
            lsb_reg <= {sum[0], lsb_reg[15:1]};
        end
    end

    // after 17 steps acc = floor(frac*d / 2^17); one bit of lsb_reg restores >>>16
    assign result = word_t'(lo_reg + DataBits'({acc_reg[31:0], lsb_reg[15]}));
    assign busy   = busy_reg;
    assign done   = done_reg;

    `include "table_linear_interpolator_unit_assert.svh"
    `TLI_ASSERT(mac_cnt_idle, busy_reg || (cnt_reg == 5'd0), "mac count left over")
    `TLI_ASSERT_NEXT(mac_done_end, busy_reg && (cnt_reg == 5'd1), done_reg, "mac end missed")
    `TLI_ASSERT(mac_done_excl, !(done_reg && busy_reg), "mac done while busy")

endmodule

// File: rtl/table_linear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// table_linear_interpolator_unit
// property table with piecewise-linear interpolation by temperature
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A row write keeps busy
// high in the cycle after the transfer, in S_WRITE. A query walks the table one
// row a cycle to find the bracketing pair, reads both rows, runs a 49-step
// bit-serial divider for the fraction and then seven 17-step serial multiplies
// on one shared shift-add unit. Empty, above-range, below-range and first-row
// queries skip the divider and the multiplies. The result is shown for exactly
// one cycle with valid_out high and cannot be stalled; busy stays high through
// that cycle.
module table_linear_interpolator_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cfg_we,
    input  logic [tli_pkg::CountBits-1:0]     cfg_wdata,
    input  logic                              opcode,
    input  logic [tli_pkg::RowBits-1:0]       row_index,
    input  logic signed [31:0]                temperature,
    input  logic signed [31:0]                density_in,
    input  logic signed [31:0]                heat_capacity_in,
    input  logic signed [31:0]                dyn_viscosity_in,
    input  logic signed [31:0]                kin_viscosity_in,
    input  logic signed [31:0]                conductivity_in,
    input  logic signed [31:0]                diffusivity_in,
    input  logic signed [31:0]                prandtl_in,
    output logic                              valid_out,
    output logic [1:0]                        status,
    output logic signed [31:0]                density_out,
    output logic signed [31:0]                heat_capacity_out,
    output logic signed [31:0]                dyn_viscosity_out,
    output logic signed [31:0]                kin_viscosity_out,
    output logic signed [31:0]                conductivity_out,
    output logic signed [31:0]                diffusivity_out,
    output logic signed [31:0]                prandtl_out
);
    import tli_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LAST  = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_RDLO  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_MAC   = 4'd7;
    localparam logic [3:0] S_MWAIT = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_WRITE = 4'd10;

    localparam logic [CountBits-1:0] MaxCount = CountBits'(MaxRows);

    // one memory, each word a whole row: temperature then properties
    logic [8*DataBits-1:0] mem [MaxRows];
    logic [8*DataBits-1:0] rd_data;
    logic [8*DataBits-1:0] wr_row;
    logic [8*DataBits-1:0] hi_reg;
    logic [RowBits-1:0]    rd_addr;
    logic                  mem_we;
    logic                  accept;

    logic [3:0]            state_reg, state_next;
    logic [CountBits-1:0]  count_reg;
    logic [RowBits-1:0]    idx_reg, idx_next;
    word_t                 t_reg;
    logic [1:0]            status_reg, status_next;
    prop_vec_t             out_reg;
    logic                  valid_reg;
    logic [2:0]            prop_reg, prop_next;
    logic [FracBits-1:0]   frac_reg;
    word_t                 t_row;
    word_t                 t_lo;

    logic                  div_start, div_busy, div_done;
    logic                  mac_start, mac_busy, mac_done;
    logic [FracBits-1:0]   quot;
    word_t                 mac_res;
    word_t                 v_lo_sel, v_hi_sel;
    logic [32:0]           div_num, div_den;

    assign accept = start && !busy;
    assign t_row = word_t'(rd_data[DataBits-1:0]);
    assign t_lo  = t_row;
    assign wr_row = {prandtl_in, diffusivity_in, conductivity_in, kin_viscosity_in,
                     dyn_viscosity_in, heat_capacity_in, density_in, temperature};
    assign mem_we = accept && (opcode == OP_WRITE);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[row_index] <= wr_row;
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cfg_we)
            count_reg <= (cfg_wdata > MaxCount) ? MaxCount : cfg_wdata;
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        prop_next   = prop_reg;
        rd_addr     = idx_reg;
        div_start   = 1'b0;
        mac_start   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = RowBits'(count_reg - CountBits'(1));
                if (accept)
                begin
                    if (opcode == OP_WRITE)
                        state_next = S_WRITE;
                    else if (count_reg == '0)
                    begin
                        status_next = STATUS_EMPTY;
                        state_next  = S_DONE;
                    end
                    else
                        state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                // rd_data holds the last row, fetch row 0
                rd_addr = '0;
                if (t_reg > t_row)
                begin
                    status_next = STATUS_ABOVE;
                    state_next  = S_DONE;
                end
                else
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                idx_next = '0;
                rd_addr  = '0;
                if (t_reg < t_row)
                begin
                    status_next = STATUS_BELOW;
                    state_next  = S_DONE;
                end
                else if (t_reg == t_row || count_reg == CountBits'(1))
                begin
                    status_next = STATUS_OK;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next   = RowBits'(1);
                    rd_addr    = RowBits'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // rd_data holds row idx_reg
                if (t_reg > t_row && (CountBits'(idx_reg) < count_reg - CountBits'(1)))
                begin
                    idx_next = idx_reg + RowBits'(1);
                    rd_addr  = idx_next;
                end
                else
                begin
                    rd_addr    = idx_reg - RowBits'(1);
                    state_next = S_RDLO;
                end
            end
            S_RDLO:
            begin
                rd_addr    = idx_reg - RowBits'(1);
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rd_addr = idx_reg - RowBits'(1);
                if (div_done)
                begin
                    prop_next  = '0;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                rd_addr    = idx_reg - RowBits'(1);
                mac_start  = 1'b1;
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                rd_addr = idx_reg - RowBits'(1);
                if (mac_done)
                begin
                    if (prop_reg == 3'(NumProp - 1))
                    begin
                        status_next = STATUS_OK;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        prop_next  = prop_reg + 3'd1;
                        state_next = S_MAC;
                    end
                end
            end
            S_DONE:
            begin
                prop_next  = '0;
                state_next = S_IDLE;
            end
            S_WRITE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // hi_reg takes rd_data in every scan state; the last, at scan exit, is the hi row
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SCAN)
            hi_reg <= rd_data;
        if (div_done)
            frac_reg <= quot;
    end

    always_comb
    begin
        v_lo_sel = word_t'(rd_data[DataBits*(32'(prop_reg)+1) +: DataBits]);
        v_hi_sel = word_t'(hi_reg[DataBits*(32'(prop_reg)+1) +: DataBits]);
        div_num  = 33'(t_reg) - 33'(t_lo);
        div_den  = 33'(word_t'(hi_reg[DataBits-1:0])) - 33'(t_lo);
    end

    tli_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (quot)
    );

    tli_serial_mac u_mac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mac_start),
        .frac   (frac_reg),
        .v_lo   (v_lo_sel),
        .v_hi   (v_hi_sel),
        .busy   (mac_busy),
        .done   (mac_done),
        .result (mac_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= STATUS_OK;
            idx_reg    <= '0;
            prop_reg   <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            idx_reg    <= idx_next;
            prop_reg   <= prop_next;
            valid_reg  <= (state_reg == S_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            t_reg <= temperature;
        if (state_reg == S_IDLE)
            out_reg <= '0;
        else if (state_reg == S_CHK && status_next == STATUS_OK)
            out_reg <= prop_vec_t'(rd_data[8*DataBits-1:DataBits]);
        else if (state_reg == S_MWAIT && mac_done)
            out_reg[prop_reg] <= mac_res;
    end

    assign busy              = (state_reg != S_IDLE) || valid_reg;
    assign valid_out         = valid_reg;
    assign status            = status_reg;
    assign density_out       = out_reg[0];
    assign heat_capacity_out = out_reg[1];
    assign dyn_viscosity_out = out_reg[2];
    assign kin_viscosity_out = out_reg[3];
    assign conductivity_out  = out_reg[4];
    assign diffusivity_out   = out_reg[5];
    assign prandtl_out       = out_reg[6];

    `include "table_linear_interpolator_unit_assert.svh"
    `TLI_ASSERT_NEXT(top_write_no_result, state_reg == S_WRITE, !valid_reg, "write gave a result")
    `TLI_ASSERT_NEXT(top_done_strobe, state_reg == S_DONE, valid_reg, "result strobe missed")
    `TLI_ASSERT(top_units_excl, !(div_busy && mac_busy), "divider and mac both busy")
    `TLI_ASSERT(top_count_range, count_reg <= MaxCount, "row count over range")

endmodule
